@@ rtl/core/spct_pkg.sv @@
package spct_pkg;

  // table size and handle index width
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // request kinds
  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_SET    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  // probe stages in priority order
  localparam logic [1:0] PROBE_FULL      = 2'd0;
  localparam logic [1:0] PROBE_NO_LOCAL  = 2'd1;
  localparam logic [1:0] PROBE_NO_REMOTE = 2'd2;
  localparam logic [1:0] PROBE_BLANK     = 2'd3;

  // remote port wildcard, -1 as a 17-bit pattern
  localparam logic [16:0] PORT_WILDCARD = 17'h1FFFF;

  // commands from the controller to the datapath
  typedef struct packed {
    logic       load;
    logic       probe;
    logic [1:0] probe_stage;
    logic       commit;
    logic       respond;
    logic       use_hit;
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [1:0] req_type;
    logic       hit;
  } dp_status_t;

endpackage

@@ rtl/core/socket_pair_connection_table_top.sv @@
// a lookup probes the four keys in priority order, one probe of all 64 entries per
//   cycle, and answers at the first stage that hits or after the last probe on a
//   miss; a set probes once, then writes; remove and unused kinds answer without a
//   probe; busy drops on the done cycle, so a new request can be taken then
// results are strobed on done for one cycle; the receiver cannot stall
// synchronous reset clears all valid bits, the done flag and the controller
module socket_pair_connection_table_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          req_type,
  input  logic [5:0]          conn_handle,
  input  logic [31:0]         local_addr,
  input  logic [31:0]         remote_addr,
  input  logic [15:0]         local_port,
  input  logic signed [16:0]  remote_port,
  output logic                done,
  output logic                found,
  output logic [5:0]          match_handle,
  output logic [1:0]          match_stage
);

  spct_pkg::ctrl_cmd_t  cmd;
  spct_pkg::dp_status_t status;

  // controller
  spct_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // table and compare datapath
  spct_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .req_type     (req_type),
    .conn_handle  (conn_handle),
    .local_addr   (local_addr),
    .remote_addr  (remote_addr),
    .local_port   (local_port),
    .remote_port  (remote_port),
    .done         (done),
    .found        (found),
    .match_handle (match_handle),
    .match_stage  (match_stage)
  );

  // a taken request keeps the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  // a response ends the request in the next cycle
  a_respond_done: assert property (@(posedge clk) disable iff (rst)
    cmd.respond |=> (done && !busy))
    else $error("response not strobed or block still busy");

  // only a lookup can report a match
  a_found_lookup: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (status.req_type == spct_pkg::REQ_LOOKUP))
    else $error("match reported for a non-lookup request");

endmodule

@@ rtl/core/spct_ctrl.sv @@
module spct_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  spct_pkg::dp_status_t  status,
  output spct_pkg::ctrl_cmd_t   cmd,
  output logic                  busy
);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_PROBE   = 2'd1;
  localparam logic [1:0] S_RESOLVE = 2'd2;
  localparam logic [1:0] S_WRITE   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [1:0] cnt;
  logic [1:0] cnt_next;

  assign busy = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd = '0;
    cmd.probe_stage = cnt;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          cnt_next = spct_pkg::PROBE_FULL;
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (status.req_type == spct_pkg::REQ_LOOKUP) begin
          // previous probe hit: report it, otherwise try the next key
          if ((cnt != spct_pkg::PROBE_FULL) && status.hit) begin
            cmd.respond = 1'b1;
            cmd.use_hit = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.probe = 1'b1;
            if (cnt == spct_pkg::PROBE_BLANK) begin
              state_next = S_RESOLVE;
            end else begin
              cnt_next = cnt + 2'd1;
            end
          end
        end else if (status.req_type == spct_pkg::REQ_SET) begin
          // find other holders of the tuple first
          cmd.probe = 1'b1;
          state_next = S_WRITE;
        end else begin
          cmd.commit = 1'b1;
          cmd.respond = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RESOLVE: begin
        cmd.respond = 1'b1;
        cmd.use_hit = status.hit;
        state_next = S_IDLE;
      end
      S_WRITE: begin
        cmd.commit = 1'b1;
        cmd.respond = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= spct_pkg::PROBE_FULL;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

endmodule

@@ rtl/core/spct_dp.sv @@
module spct_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  spct_pkg::ctrl_cmd_t   cmd,
  output spct_pkg::dp_status_t  status,
  input  logic [1:0]            req_type,
  input  logic [5:0]            conn_handle,
  input  logic [31:0]           local_addr,
  input  logic [31:0]           remote_addr,
  input  logic [15:0]           local_port,
  input  logic signed [16:0]    remote_port,
  output logic                  done,
  output logic                  found,
  output logic [5:0]            match_handle,
  output logic [1:0]            match_stage
);

  localparam int DEPTH = spct_pkg::TABLE_DEPTH;
  localparam int IW = spct_pkg::IDX_W;

  // latched request
  logic [1:0]  req_kind;
  logic [5:0]  req_handle;
  logic [31:0] req_laddr;
  logic [31:0] req_raddr;
  logic [15:0] req_lport;
  logic [16:0] req_rport;

  // table entries
  logic              ent_valid [DEPTH];
  logic [31:0]       ent_laddr [DEPTH];
  logic [31:0]       ent_raddr [DEPTH];
  logic [32:0]       ent_ports [DEPTH];

  // probe key and match
  logic [31:0]       key_laddr;
  logic [31:0]       key_raddr;
  logic [32:0]       key_ports;
  logic [DEPTH-1:0]  match;
  logic [DEPTH-1:0]  hit_vec;
  logic [1:0]        hit_stage;
  logic [IW-1:0]     hit_idx;
  logic [IW-1:0]     req_idx;
  logic              handle_ok;

  assign req_idx = IW'(req_handle);
  assign handle_ok = (32'(req_handle) < 32'(DEPTH));

  assign status.req_type = req_kind;
  assign status.hit = |hit_vec;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind <= req_type;
      req_handle <= conn_handle;
      req_laddr <= local_addr;
      req_raddr <= remote_addr;
      req_lport <= local_port;
      req_rport <= remote_port;
    end
  end

  // key for the current probe stage
  always_comb begin
    key_laddr = req_laddr;
    key_raddr = req_raddr;
    key_ports = {req_lport, req_rport};
    case (cmd.probe_stage)
      spct_pkg::PROBE_FULL: begin
      end
      spct_pkg::PROBE_NO_LOCAL: begin
        key_laddr = '0;
      end
      spct_pkg::PROBE_NO_REMOTE: begin
        key_raddr = '0;
        key_ports = {req_lport, spct_pkg::PORT_WILDCARD};
      end
      spct_pkg::PROBE_BLANK: begin
        key_laddr = '0;
        key_raddr = '0;
        key_ports = {req_lport, spct_pkg::PORT_WILDCARD};
      end
      default: begin
      end
    endcase
  end

  // compare against every entry at once
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = ent_valid[i] && (ent_laddr[i] == key_laddr) &&
                 (ent_raddr[i] == key_raddr) && (ent_ports[i] == key_ports);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.probe) begin
      hit_vec <= match;
      hit_stage <= cmd.probe_stage;
    end
  end

  // handle encoder, at most one entry holds any tuple
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_idx = hit_idx | (hit_vec[i] ? IW'(i) : IW'(0));
    end
  end

  // entry payload write on set
  always_ff @(posedge clk) begin
    if (cmd.commit && (req_kind == spct_pkg::REQ_SET) && handle_ok) begin
      ent_laddr[req_idx] <= req_laddr;
      ent_raddr[req_idx] <= req_raddr;
      ent_ports[req_idx] <= {req_lport, req_rport};
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        ent_valid[i] <= 1'b0;
      end
    end else if (cmd.commit && handle_ok) begin
      if (req_kind == spct_pkg::REQ_SET) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (hit_vec[i] && (IW'(i) != req_idx)) begin
            ent_valid[i] <= 1'b0;
          end
        end
        ent_valid[req_idx] <= 1'b1;
      end else if (req_kind == spct_pkg::REQ_REMOVE) begin
        ent_valid[req_idx] <= 1'b0;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      found <= cmd.use_hit;
      match_handle <= cmd.use_hit ? 6'(hit_idx) : 6'd0;
      match_stage <= cmd.use_hit ? hit_stage : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.respond;
    end
  end

endmodule

@@ bench/socket_pair_connection_table_checker.sv @@
`timescale 1ns / 100ps

module socket_pair_connection_table_checker
  import spct_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  req_type,
  input  logic [5:0]  conn_handle,
  input  logic [31:0] local_addr,
  input  logic [31:0] remote_addr,
  input  logic [15:0] local_port,
  input  logic [16:0] remote_port,
  input  logic        done,
  input  logic        found,
  input  logic [5:0]  match_handle,
  input  logic [1:0]  match_stage,
  output int          mismatch_count,
  output int          outstanding
);

  typedef struct packed {
    logic       found;
    logic [5:0] handle;
    logic [1:0] stage;
  } reply_t;

  // shadow copy of the connection table
  logic        slot_valid [TABLE_DEPTH];
  logic [31:0] slot_laddr [TABLE_DEPTH];
  logic [31:0] slot_raddr [TABLE_DEPTH];
  logic [32:0] slot_ports [TABLE_DEPTH];

  reply_t expected_replies[$];

  // lowest valid handle holding the tuple, -1 when none
  function automatic int find_slot(logic [31:0] la, logic [31:0] ra, logic [32:0] pp);
    for (int h = 0; h < TABLE_DEPTH; h++) begin
      if (slot_valid[h] && slot_laddr[h] == la && slot_raddr[h] == ra && slot_ports[h] == pp)
        return h;
    end
    return -1;
  endfunction

  // applies one request to the shadow table and returns the reply it should give
  function automatic reply_t apply_request(logic [1:0] kind, logic [5:0] handle,
                                           logic [31:0] la, logic [31:0] ra,
                                           logic [15:0] lp, logic [16:0] rp);
    reply_t      r;
    int          hit;
    logic [32:0] full_ports;
    logic [32:0] blank_ports;
    r = '0;
    full_ports = {lp, rp};
    blank_ports = {lp, PORT_WILDCARD};
    case (kind)
      REQ_LOOKUP: begin
        hit = find_slot(la, ra, full_ports);
        r.stage = PROBE_FULL;
        if (hit < 0) begin
          hit = find_slot(32'd0, ra, full_ports);
          r.stage = PROBE_NO_LOCAL;
        end
        if (hit < 0) begin
          hit = find_slot(la, 32'd0, blank_ports);
          r.stage = PROBE_NO_REMOTE;
        end
        if (hit < 0) begin
          hit = find_slot(32'd0, 32'd0, blank_ports);
          r.stage = PROBE_BLANK;
        end
        if (hit >= 0) begin
          r.found = 1'b1;
          r.handle = hit[5:0];
        end else begin
          r.stage = PROBE_FULL;
        end
      end
      REQ_SET: begin
        // a tuple lives in one entry only: drop any other holder
        for (int h = 0; h < TABLE_DEPTH; h++) begin
          if (h != handle && slot_valid[h] && slot_laddr[h] == la && slot_raddr[h] == ra
              && slot_ports[h] == full_ports)
            slot_valid[h] = 1'b0;
        end
        slot_laddr[handle] = la;
        slot_raddr[handle] = ra;
        slot_ports[handle] = full_ports;
        slot_valid[handle] = 1'b1;
      end
      REQ_REMOVE: begin
        slot_valid[handle] = 1'b0;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // match replies against predictions, then predict for a newly taken request
  always @(posedge clk) begin : watch
    reply_t want;
    if (rst) begin
      for (int h = 0; h < TABLE_DEPTH; h++) slot_valid[h] = 1'b0;
      expected_replies.delete();
      mismatch_count = 0;
    end else begin
      if (done) begin
        if (expected_replies.size() == 0) begin
          $error("reply with no request pending: found %0d handle %0d stage %0d",
                 found, match_handle, match_stage);
          mismatch_count++;
        end else begin
          want = expected_replies.pop_front();
          if (found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found);
            mismatch_count++;
          end
          if (match_handle !== want.handle) begin
            $error("match_handle: expected %0d, got %0d", want.handle, match_handle);
            mismatch_count++;
          end
          if (match_stage !== want.stage) begin
            $error("match_stage: expected %0d, got %0d", want.stage, match_stage);
            mismatch_count++;
          end
        end
      end
      if (start && !busy)
        expected_replies.push_back(apply_request(req_type, conn_handle, local_addr,
                                                 remote_addr, local_port, remote_port));
    end
    outstanding = expected_replies.size();
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import spct_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 1950;
  localparam int CALM_TAIL = 250;
  localparam int CYCLE_LIMIT = 200000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [1:0]         req_type = '0;
  logic [5:0]         conn_handle = '0;
  logic [31:0]        local_addr = '0;
  logic [31:0]        remote_addr = '0;
  logic [15:0]        local_port = '0;
  logic signed [16:0] remote_port = '0;
  logic               busy;
  logic               done;
  logic               found;
  logic [5:0]         match_handle;
  logic [1:0]         match_stage;

  int mismatch_count;
  int outstanding;
  int cycle_count = 0;

  // small pools of tuple parts so lookups keep hitting stored entries
  logic [31:0] laddr_pool [4];
  logic [31:0] raddr_pool [3];
  logic [15:0] lport_pool [3];
  logic [16:0] rport_pool [3];

  always #5 clk = ~clk;

  socket_pair_connection_table_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .conn_handle  (conn_handle),
    .local_addr   (local_addr),
    .remote_addr  (remote_addr),
    .local_port   (local_port),
    .remote_port  (remote_port),
    .done         (done),
    .found        (found),
    .match_handle (match_handle),
    .match_stage  (match_stage)
  );

  socket_pair_connection_table_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .req_type       (req_type),
    .conn_handle    (conn_handle),
    .local_addr     (local_addr),
    .remote_addr    (remote_addr),
    .local_port     (local_port),
    .remote_port    (remote_port),
    .done           (done),
    .found          (found),
    .match_handle   (match_handle),
    .match_stage    (match_stage),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // present one request and hold it until the block is no longer busy
  task automatic send_request(logic [1:0] kind, logic [5:0] handle, logic [31:0] la,
                              logic [31:0] ra, logic [15:0] lp, logic [16:0] rp);
    @(negedge clk);
    start <= 1'b1;
    req_type <= kind;
    conn_handle <= handle;
    local_addr <= la;
    remote_addr <= ra;
    local_port <= lp;
    remote_port <= rp;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // hold off until every pending reply has come back
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int          roll;
    logic [1:0]  kind;
    logic [5:0]  handle;
    logic [31:0] la;
    logic [31:0] ra;
    logic [15:0] lp;
    logic [16:0] rp;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: miss on an empty table
    send_request(REQ_LOOKUP, 6'd0, 32'd0, 32'd0, 16'd0, 17'd0);
    // all-ones tuple at handle 0, exact hit
    send_request(REQ_SET, 6'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 17'h0FFFF);
    send_request(REQ_LOOKUP, 6'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 17'h0FFFF);
    // unspecified local address, hit on the second probe
    send_request(REQ_SET, 6'd63, 32'd0, 32'h0A00_0002, 16'd80, 17'd1234);
    send_request(REQ_LOOKUP, 6'd0, 32'hC0A8_0101, 32'h0A00_0002, 16'd80, 17'd1234);
    // listening entry with blank remote side, hit on the third probe
    send_request(REQ_SET, 6'd5, 32'hC0A8_0105, 32'd0, 16'd443, PORT_WILDCARD);
    send_request(REQ_LOOKUP, 6'd0, 32'hC0A8_0105, 32'h0B0B_0B0B, 16'd443, 17'd7);
    // fully blank entry, hit on the last probe
    send_request(REQ_SET, 6'd6, 32'd0, 32'd0, 16'd22, PORT_WILDCARD);
    send_request(REQ_LOOKUP, 6'd0, 32'h0102_0304, 32'h0506_0708, 16'd22, 17'd9);
    // exact entry wins over the blank one
    send_request(REQ_SET, 6'd9, 32'h0102_0304, 32'h0506_0708, 16'd22, 17'd9);
    send_request(REQ_LOOKUP, 6'd0, 32'h0102_0304, 32'h0506_0708, 16'd22, 17'd9);
    // setting a tuple already held elsewhere drops the old holder
    send_request(REQ_SET, 6'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 17'h0FFFF);
    send_request(REQ_LOOKUP, 6'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 17'h0FFFF);
    send_request(REQ_REMOVE, 6'd7, 32'd0, 32'd0, 16'd0, 17'd0);
    send_request(REQ_LOOKUP, 6'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 17'h0FFFF);
    // remote ports outside the legal range are kept as raw patterns
    send_request(REQ_SET, 6'd1, 32'h0000_0001, 32'h8000_0000, 16'd0, 17'h10000);
    send_request(REQ_LOOKUP, 6'd0, 32'h0000_0001, 32'h8000_0000, 16'd0, 17'h10000);
    send_request(REQ_LOOKUP, 6'd0, 32'h0000_0001, 32'h8000_0000, 16'd0, 17'h00000);
    send_request(REQ_SET, 6'd2, 32'h0000_0001, 32'h8000_0000, 16'd0, 17'h1FFFE);
    send_request(REQ_LOOKUP, 6'd0, 32'h0000_0001, 32'h8000_0000, 16'd0, 17'h1FFFE);
    // unused kind changes nothing
    send_request(REQ_UNUSED, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 17'h1FFFF);
    send_request(REQ_REMOVE, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 17'h1FFFF);
    send_request(REQ_LOOKUP, 6'd0, 32'hC0A8_0101, 32'h0A00_0002, 16'd80, 17'd1234);
    wait_drained();

    // random part
    foreach (laddr_pool[i]) laddr_pool[i] = (i == 0) ? 32'd0 : $urandom;
    foreach (raddr_pool[i]) raddr_pool[i] = (i == 0) ? 32'd0 : $urandom;
    foreach (lport_pool[i]) lport_pool[i] = 16'($urandom);
    foreach (rport_pool[i])
      rport_pool[i] = (i == 0) ? PORT_WILDCARD : 17'($urandom_range(65535));

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        // unrestricted noise
        kind = 2'($urandom_range(3));
        handle = 6'($urandom_range(63));
        la = $urandom;
        ra = $urandom;
        lp = 16'($urandom);
        rp = 17'($urandom);
      end else begin
        roll = $urandom_range(99);
        if (roll < 50) kind = REQ_LOOKUP;
        else if (roll < 80) kind = REQ_SET;
        else if (roll < 95) kind = REQ_REMOVE;
        else kind = REQ_UNUSED;
        handle = ($urandom_range(4) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(15));
        la = laddr_pool[2'($urandom_range(3))];
        ra = raddr_pool[2'($urandom_range(2))];
        lp = lport_pool[2'($urandom_range(2))];
        rp = rport_pool[2'($urandom_range(2))];
      end
      send_request(kind, handle, la, ra, lp, rp);

      // sender gaps, none in the closing stretch
      if (n < RANDOM_REQUESTS - CALM_TAIL) begin
        if (n % 400 == 399)
          wait_drained();
        else if ($urandom_range(3) == 0)
          idle_cycles($urandom_range(1, 7));
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
